// ----- rtl/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Command and status codes, controller states, control word and the fixed
// widths of the result word shared by the table's modules.
// ----------------------------------------------------------------------------
package skvt_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_APPLY   = 2'd2
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the incoming word
    logic compare;  // register the per-entry compare results
    logic apply;    // write the table and load the result register
  } ctrl_cmd_t;

  // Fixed result field widths
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned READ_VALUE_W = 32;
  localparam int unsigned POSITION_W   = 4;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned OUT_FIELDS_W = READ_VALUE_W + POSITION_W + STATUS_W + COUNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ----- rtl/sorted_key_value_table.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value table
// Bounded table of key/value pairs kept in ascending key order, driven by
// insert, update and lookup commands over a pair of stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry the command on s_axis_tuser and the key and value on
//   s_axis_tdata. Each command returns exactly one result word on m_axis:
//   read value, sorted position, status and the entry count after the command.
//   The word is captured on acceptance, its compare results are then
//   registered, and the apply step then loads the result. A new command is
//   taken only when idle or in the apply step that finishes the last one, as
//   the compare step against all entries precedes the write-back/shift step on the same table.
//   A full result register that the receiver does not take holds the
//   finished command in the apply step and keeps s_axis_tready low until the
//   result register frees. An idle table still takes one word while a result
//   waits; that word then holds in the apply step.
//   Reset empties the table (count zero); entry contents are not cleared and
//   are never read above the count.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [KEY_BITS-1:0] key, then new_value above it, zero padded to bytes
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [skvt_pkg::CMD_W-1:0]            s_axis_tuser,
  // result words
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] read_value, [35:32] position, [37:36] status, [42:38] entry_count
  output logic [skvt_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  skvt_pkg::ctrl_cmd_t ctrl;

  // Handshake and sequencing
  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .ctrl_o     (ctrl)
  );

  // Table storage and compare/shift logic
  skvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cmd_i      (s_axis_tuser),
    .key_i      (s_axis_tdata[KEY_BITS-1:0]),
    .value_i    (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- rtl/skvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences each command through compare and apply, and owns both stream
// handshakes including the valid flag of the result register.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output skvt_pkg::ctrl_cmd_t ctrl_o
);

  skvt_pkg::state_e state_q, state_d;
  logic             m_tvalid_q, m_tvalid_d;
  logic             out_free;

  // Result register can take a new word this cycle
  assign out_free = !m_tvalid_q || m_tready_i;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    s_tready_o     = 1'b0;
    ctrl_o.load    = 1'b0;
    ctrl_o.compare = 1'b0;
    ctrl_o.apply   = 1'b0;
    unique case (state_q)
      skvt_pkg::S_IDLE: begin
        s_tready_o  = 1'b1;
        ctrl_o.load = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = skvt_pkg::S_COMPARE;
        end
      end
      skvt_pkg::S_COMPARE: begin
        ctrl_o.compare = 1'b1;
        state_d        = skvt_pkg::S_APPLY;
      end
      skvt_pkg::S_APPLY: begin
        // finish only when the result register is free; take the next word then
        if (out_free) begin
          ctrl_o.apply = 1'b1;
          s_tready_o   = 1'b1;
          ctrl_o.load  = s_tvalid_i;
          state_d      = s_tvalid_i ? skvt_pkg::S_COMPARE : skvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skvt_pkg::S_IDLE;
      end
    endcase
  end

  // Set on a finished command, clear when the word is taken
  assign m_tvalid_d = ctrl_o.apply || (m_tvalid_q && !m_tready_i);
  assign m_tvalid_o = m_tvalid_q;

  // State and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= skvt_pkg::S_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

endmodule

// ----- rtl/skvt_datapath.sv -----
// ----------------------------------------------------------------------------
// Sorted key/value table datapath
// One compare cell per entry finds the lower bound and the hit; the apply
// step shifts entries up for an insert or rewrites the value of a hit.
// ----------------------------------------------------------------------------
module skvt_datapath #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  skvt_pkg::ctrl_cmd_t             ctrl_i,
  input  logic [skvt_pkg::CMD_W-1:0]      cmd_i,
  input  logic [KEY_BITS-1:0]             key_i,
  input  logic [VALUE_BITS-1:0]           value_i,
  output logic [skvt_pkg::OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Captured command
  skvt_pkg::cmd_e        cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // Table cells and count
  logic [KEY_BITS-1:0]   key_mem_q [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem_q [CAPACITY];
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Per-cell compare results
  logic [CAPACITY-1:0]   lt_c, eq_c, lt_q, eq_q;
  logic [CAPACITY-1:0]   first, wr_en;

  // Apply step
  logic                  hit, full, ins_new, val_wr;
  logic [IDX_W-1:0]      idx, pos;
  logic [VALUE_BITS-1:0] hit_val, rv;
  skvt_pkg::status_e     st;
  logic [63:0]           rv_ext;
  logic [15:0]           pos_ext, cnt_ext;
  logic [skvt_pkg::OUT_DATA_W-1:0] out_data_q;

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= skvt_pkg::cmd_e'(cmd_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Compare cells and table entries
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic                  cell_valid;
    logic [KEY_BITS-1:0]   prev_key;
    logic [VALUE_BITS-1:0] prev_val;

    assign cell_valid = CNT_W'(j) < cnt_q;
    assign lt_c[j]    = cell_valid && (key_mem_q[j] < key_q);
    assign eq_c[j]    = cell_valid && (key_mem_q[j] == key_q);

    if (j == 0) begin : g_head
      assign first[j] = !lt_q[j];
      assign prev_key = key_q;
      assign prev_val = value_q;
    end else begin : g_body
      assign first[j] = !lt_q[j] && lt_q[j-1];
      assign prev_key = key_mem_q[j-1];
      assign prev_val = val_mem_q[j-1];
    end

    // Insert writes every entry from the lower bound up; a hit writes its own entry
    assign wr_en[j] = ctrl_i.apply && (ins_new ? !lt_q[j] : (val_wr && eq_q[j]));

    always_ff @(posedge clk_i) begin
      if (wr_en[j]) begin
        key_mem_q[j] <= first[j] ? key_q   : prev_key;
        val_mem_q[j] <= first[j] ? value_q : prev_val;
      end
    end
  end

  // Register compare results
  always_ff @(posedge clk_i) begin
    if (ctrl_i.compare) begin
      lt_q <= lt_c;
      eq_q <= eq_c;
    end
  end

  // Encode the lower bound and pick the hit value
  always_comb begin
    idx     = '0;
    hit_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (first[j]) idx = idx | IDX_W'(j);
      if (eq_q[j])  hit_val = hit_val | val_mem_q[j];
    end
  end

  assign hit  = |eq_q;
  assign full = (cnt_q == CNT_W'(CAPACITY));

  // Decide the command outcome
  always_comb begin
    ins_new = 1'b0;
    val_wr  = 1'b0;
    rv      = '0;
    pos     = '0;
    st      = skvt_pkg::ST_OK;
    cnt_d   = cnt_q;
    unique case (cmd_q)
      skvt_pkg::CMD_INSERT: begin
        if (hit) begin
          val_wr = 1'b1;
          pos    = idx;
        end else if (full) begin
          st = skvt_pkg::ST_FULL;
        end else begin
          ins_new = 1'b1;
          cnt_d   = CNT_W'(cnt_q + 1'b1);
          pos     = idx;
        end
      end
      skvt_pkg::CMD_UPDATE, skvt_pkg::CMD_LOOKUP: begin
        if (cnt_q == '0) begin
          st = skvt_pkg::ST_EMPTY;
        end else if (!hit) begin
          st = skvt_pkg::ST_MISSING;
        end else begin
          pos = idx;
          if (cmd_q == skvt_pkg::CMD_UPDATE) begin
            val_wr = 1'b1;
          end else begin
            rv = hit_val;
          end
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // Fit fields to the fixed result widths
  assign rv_ext  = 64'(rv);
  assign pos_ext = 16'(pos);
  assign cnt_ext = 16'(cnt_d);

  // Count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.apply) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      out_data_q <= skvt_pkg::OUT_DATA_W'({cnt_ext[skvt_pkg::COUNT_W-1:0], st,
                                          pos_ext[skvt_pkg::POSITION_W-1:0],
                                          rv_ext[skvt_pkg::READ_VALUE_W-1:0]});
    end
  end

  assign out_data_o = out_data_q;

  // Count moves by at most one per command
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply |=> (cnt_q == $past(cnt_q)) || (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("entry count moved by more than one");

  // Lower bound marker is at most one entry
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply |-> $onehot0(first))
    else $error("lower bound marker is not one-hot");

  // A hit sits exactly at the lower bound
  a_hit_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && hit) |-> (eq_q == first))
    else $error("hit entry differs from lower bound");

  // A full table never grows
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && full) |=> (cnt_q == CNT_W'(CAPACITY)))
    else $error("entry count grew past capacity");

endmodule

// ----- bench/sorted_key_value_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key/value table testbench
// Drives insert, update and lookup words into the table and checks every
// result word against a written expectation or the bench's sorted shadow table.
// A short table of directed words covers the empty, single-entry, duplicate,
// unused-command and full cases. A random run of mostly stored keys follows,
// with bursty input, a receiver that stalls on its own pattern, one long
// receiver hold-off and one pause that waits for every pending result.
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_AT      = 250;
  localparam int SETTLE_AT    = 550;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 2_000_000;

  // Command code that the table ignores
  localparam logic [skvt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_e;

  typedef struct packed {
    logic [skvt_pkg::READ_VALUE_W-1:0] read_value;
    logic [skvt_pkg::POSITION_W-1:0]   position;
    skvt_pkg::status_e                 status;
    logic [skvt_pkg::COUNT_W-1:0]      entry_count;
  } table_result_t;

  typedef struct {
    logic [skvt_pkg::CMD_W-1:0] cmd;
    logic [KEY_BITS-1:0]        key;
    logic [VALUE_BITS-1:0]      value;
    bit                         typed;
    table_result_t              want;
  } directed_row_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [15:0] key, [47:16] new_value
  logic [IN_DATA_W-1:0]            s_axis_tdata  = '0;
  // [1:0] cmd
  logic [skvt_pkg::CMD_W-1:0]      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [31:0] read_value, [35:32] position, [37:36] status, [42:38] entry_count
  logic [skvt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the sorted table
  logic [KEY_BITS-1:0]   shadow_keys   [CAPACITY];
  logic [VALUE_BITS-1:0] shadow_values [CAPACITY];
  int                    shadow_count = 0;

  table_result_t pending_results[$];
  directed_row_t directed_rows[$];
  int            error_count      = 0;
  bit            hold_off_request = 1'b0;

  sorted_key_value_table #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one command to the shadow table and return the result it yields
  function automatic table_result_t apply_table_command(
    input logic [skvt_pkg::CMD_W-1:0] cmd,
    input logic [KEY_BITS-1:0]        key,
    input logic [VALUE_BITS-1:0]      value
  );
    table_result_t res;
    int            slot;
    bit            hit;
    res  = '0;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < key) slot++;
    hit = (slot < shadow_count) && (shadow_keys[slot] == key);
    case (cmd)
      skvt_pkg::CMD_INSERT: begin
        if (hit) begin
          shadow_values[slot] = value;
          res.position        = slot[skvt_pkg::POSITION_W-1:0];
        end else if (shadow_count >= CAPACITY) begin
          res.status = skvt_pkg::ST_FULL;
        end else begin
          // open a slot by shifting the upper entries up by one
          for (int j = shadow_count; j > slot; j--) begin
            shadow_keys[j]   = shadow_keys[j-1];
            shadow_values[j] = shadow_values[j-1];
          end
          shadow_keys[slot]   = key;
          shadow_values[slot] = value;
          shadow_count++;
          res.position = slot[skvt_pkg::POSITION_W-1:0];
        end
      end
      skvt_pkg::CMD_UPDATE, skvt_pkg::CMD_LOOKUP: begin
        if (shadow_count == 0) begin
          res.status = skvt_pkg::ST_EMPTY;
        end else if (!hit) begin
          res.status = skvt_pkg::ST_MISSING;
        end else begin
          res.position = slot[skvt_pkg::POSITION_W-1:0];
          if (cmd == skvt_pkg::CMD_UPDATE) shadow_values[slot] = value;
          else res.read_value = shadow_values[slot];
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_count[skvt_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic void add_row(
    input logic [skvt_pkg::CMD_W-1:0]        cmd,
    input logic [KEY_BITS-1:0]               key,
    input logic [VALUE_BITS-1:0]             value,
    input bit                                typed,
    input logic [skvt_pkg::READ_VALUE_W-1:0] read_value,
    input logic [skvt_pkg::POSITION_W-1:0]   position,
    input skvt_pkg::status_e                 status,
    input logic [skvt_pkg::COUNT_W-1:0]      entry_count
  );
    directed_row_t row;
    row.cmd              = cmd;
    row.key              = key;
    row.value            = value;
    row.typed            = typed;
    row.want.read_value  = read_value;
    row.want.position    = position;
    row.want.status      = status;
    row.want.entry_count = entry_count;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Offer one word at this edge and hold it until the table takes it
  task automatic send_word(
    input  logic [skvt_pkg::CMD_W-1:0] cmd,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [VALUE_BITS-1:0]      value,
    output table_result_t              predicted
  );
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {value, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_table_command(cmd, key, value);
  endtask

  task automatic idle_input(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Check each result word against the oldest pending result
  always @(posedge clk_i) begin : result_checker
    table_result_t got;
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_value  = m_axis_tdata[31:0];
      got.position    = m_axis_tdata[35:32];
      got.status      = skvt_pkg::status_e'(m_axis_tdata[37:36]);
      got.entry_count = m_axis_tdata[42:38];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.read_value != want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.position != want.position)
          report_mismatch("position", 32'(got.position), 32'(want.position));
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      end
    end
  end

  // Receiver: stretches of steady, random or sparse ready, plus one long hold-off
  initial begin : receiver
    ready_mode_e mode;
    int          stretch;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_request && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode    = ready_mode_e'($urandom_range(0, 2));
      stretch = $urandom_range(8, 64);
      repeat (stretch) begin
        case (mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
          default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    table_result_t              predicted;
    logic [skvt_pkg::CMD_W-1:0] cmd;
    logic [KEY_BITS-1:0]        key;
    logic [VALUE_BITS-1:0]      value;
    int                         pick;
    int                         burst_left;
    logic [KEY_BITS-1:0]        fill_keys[14];

    fill_keys = '{16'h8000, 16'h4000, 16'hC000, 16'h2000, 16'hA000, 16'h6000, 16'hE000,
                  16'h1000, 16'h9000, 16'h5000, 16'hD000, 16'h3000, 16'hB000, 16'h7000};

    // empty table, then a single entry whose key must still be compared
    add_row(skvt_pkg::CMD_LOOKUP, 16'h1234, 32'h0, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_EMPTY, 5'd0);
    add_row(skvt_pkg::CMD_UPDATE, 16'h1234, 32'h0, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_EMPTY, 5'd0);
    add_row(skvt_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_OK, 5'd1);
    add_row(skvt_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0, 1'b1, 32'hFFFF_FFFF, 4'd0,
            skvt_pkg::ST_OK, 5'd1);
    add_row(skvt_pkg::CMD_LOOKUP, 16'h0000, 32'h0, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_MISSING, 5'd1);
    add_row(skvt_pkg::CMD_UPDATE, 16'h0000, 32'h1, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_MISSING, 5'd1);
    add_row(skvt_pkg::CMD_INSERT, 16'h0000, 32'h0, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_OK, 5'd2);
    // duplicate insert overwrites, the unused code changes nothing
    add_row(skvt_pkg::CMD_INSERT, 16'hFFFF, 32'h5A5A_5A5A, 1'b0, '0, '0,
            skvt_pkg::ST_OK, '0);
    add_row(CMD_UNUSED, 16'h5555, 32'hDEAD_BEEF, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_OK, 5'd2);
    add_row(skvt_pkg::CMD_UPDATE, 16'h0000, 32'hA5A5_A5A5, 1'b0, '0, '0,
            skvt_pkg::ST_OK, '0);
    // fill the table in scattered order so inserts shift at many positions
    foreach (fill_keys[i])
      add_row(skvt_pkg::CMD_INSERT, fill_keys[i], {fill_keys[i], ~fill_keys[i]}, 1'b0,
              '0, '0, skvt_pkg::ST_OK, '0);
    add_row(skvt_pkg::CMD_INSERT, 16'h0001, 32'h1234_5678, 1'b1, 32'h0, 4'd0,
            skvt_pkg::ST_FULL, 5'd16);
    add_row(skvt_pkg::CMD_LOOKUP, 16'h7000, 32'h0, 1'b0, '0, '0, skvt_pkg::ST_OK, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
                predicted);
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
      pick = $urandom_range(0, 3);
      if (pick != 0) idle_input(pick);
    end

    // random words, mostly on stored keys, sent in bursts
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
      end
      if (n == HOLD_AT) hold_off_request = 1'b1;
      if (n == SETTLE_AT) begin
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end

      pick = $urandom_range(0, 49);
      if (pick == 0) cmd = CMD_UNUSED;
      else if (pick < 20) cmd = skvt_pkg::CMD_INSERT;
      else if (pick < 33) cmd = skvt_pkg::CMD_UPDATE;
      else cmd = skvt_pkg::CMD_LOOKUP;

      pick = $urandom_range(0, 9);
      if (pick < 7 && shadow_count > 0) key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else if (pick == 7) key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else key = 16'($urandom());

      pick = $urandom_range(0, 7);
      if (pick == 0) value = 32'h0;
      else if (pick == 1) value = 32'hFFFF_FFFF;
      else value = $urandom();

      send_word(cmd, key, value, predicted);
      pending_results.push_back(predicted);
      burst_left--;
    end

    // drain, then keep checking for any stray result word
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS sorted_key_value_table");
    end else begin
      $display("FAIL sorted_key_value_table");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL sorted_key_value_table");
    $finish;
  end

endmodule

// ----- sorted_key_value_table.f -----
rtl/skvt_pkg.sv
rtl/skvt_ctrl.sv
rtl/skvt_datapath.sv
rtl/sorted_key_value_table.sv
bench/sorted_key_value_table_test.sv
